[rtl/sp24_pkg.sv]
`default_nettype none
package sp24_pkg;
  localparam int MaxCols    = 64;
  localparam int MaxInner   = 256;
  localparam int ValueWidth = 16;
  localparam int AccWidth   = 40;

  localparam logic [1:0] CfgNCols = 2'd0;
  localparam logic [1:0] CfgKCols = 2'd1;
  localparam logic [1:0] CfgMRows = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [7:0]  b_row;
    logic [5:0]  b_col;
    logic signed [15:0] b_value;
    logic signed [15:0] a_value0;
    logic [1:0]  a_pos0;
    logic signed [15:0] a_value1;
    logic [1:0]  a_pos1;
    logic        second_valid;
    logic        row_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] c_row;
    logic [5:0]  c_col;
    logic signed [39:0] c_value;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_EMIT, ST_CLEAR
  } state_t;
endpackage
`default_nettype wire

[rtl/sp24_ram.sv]
`default_nettype none
module sp24_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/sparse_2_4_matmul_row_engine_core.sv]
`default_nettype none
// Load item: written to the dense store when taken. Group item: one pass per present value
// (an empty pass when its row is at or beyond k_cols): one dense-store read per column into a read,
// multiply, accumulate pipeline that drains between passes.
// Row end: one result per column, each waiting on the output stall, then one clearing write
// per accumulator entry (64 by default); the input stalls throughout.
// Reset (synchronous): n_cols 64, k_cols 256, m_rows 65535, counters zero, then that clear.
module sparse_2_4_matmul_row_engine_core #(
  parameter int MAX_COLS    = sp24_pkg::MaxCols,
  parameter int MAX_INNER   = sp24_pkg::MaxInner,
  parameter int VALUE_WIDTH = sp24_pkg::ValueWidth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sp24_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sp24_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata
);
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int KW  = $clog2(MAX_INNER);
  localparam int GPR = (MAX_INNER + 3) / 4;
  localparam int GW  = (GPR > 1) ? $clog2(GPR) : 1;
  localparam int AW  = sp24_pkg::AccWidth;

  logic [6:0]  n_cols;
  logic [8:0]  k_cols;
  logic [15:0] m_rows;
  logic [GW-1:0] grp;
  logic [15:0] row_cnt;

  sp24_pkg::state_t state, state_next;
  sp24_pkg::in_item_t item;
  logic        second;      // working on second value
  logic [6:0]  col;         // read column being issued
  logic [6:0]  ncols_act;
  logic        accept;
  logic        out_fire;

  // accumulate pipeline
  logic        mac_issue, pass_end, pipe_busy;
  logic        rd_v, prod_v, wb_v;
  logic [CW-1:0] rd_col, prod_col, wb_col;
  logic [AW-1:0] wb_data;
  logic signed [VALUE_WIDTH-1:0] a_cur, a_cur_d;
  logic signed [2*VALUE_WIDTH-1:0] prod;

  // dense store
  logic        ds_we;
  logic [KW+CW-1:0] ds_waddr, ds_raddr;
  logic [VALUE_WIDTH-1:0] ds_rdata;
  logic [KW:0] kidx;
  logic        kok;

  // accumulators
  logic        ac_we;
  logic [CW-1:0] ac_waddr, ac_raddr;
  logic [AW-1:0] ac_wdata, ac_rdata;

  // emit path
  logic        em_rd_v, em_start, em_load;
  logic [CW-1:0] em_col;
  logic [6:0]  em_issue;
  logic [6:0]  em_done;
  logic        em_last;
  logic [CW:0] clr;

  assign ncols_act = (n_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : n_cols;

  sp24_ram #(.Width(VALUE_WIDTH), .Depth((1<<KW)*(1<<CW))) u_dense (
    .clk, .we(ds_we), .waddr(ds_waddr), .wdata(VALUE_WIDTH'(in_data.b_value)),
    .raddr(ds_raddr), .rdata(ds_rdata)
  );

  sp24_ram #(.Width(AW), .Depth(1<<CW)) u_acc (
    .clk, .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
    .raddr(ac_raddr), .rdata(ac_rdata)
  );

  assign in_stall = (state != sp24_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign ds_we    = accept && !in_data.mode && (32'(in_data.b_row) < MAX_INNER)
                    && (32'(in_data.b_col) < MAX_COLS);
  assign ds_waddr = {KW'(in_data.b_row), CW'(in_data.b_col)};

  always_comb begin
    kidx = (KW+1)'({grp, 2'b00}) + (KW+1)'(second ? item.a_pos1 : item.a_pos0);
    kok  = (32'(kidx) < 32'(k_cols)) && (32'(kidx) < MAX_INNER);
  end
  assign ds_raddr = {kidx[KW-1:0], col[CW-1:0]};
  assign a_cur    = second ? VALUE_WIDTH'(item.a_value1) : VALUE_WIDTH'(item.a_value0);

  // issue -> rd (dense data, acc read issued) -> prod (acc data) -> wb (write)
  // Columns are distinct within a pass and passes drain in between, so no forwarding.
  assign mac_issue = (state == sp24_pkg::ST_MAC) && (col < ncols_act) && kok;
  assign pipe_busy = rd_v || prod_v || wb_v;
  assign pass_end  = (state == sp24_pkg::ST_MAC) && !mac_issue && !pipe_busy;

  assign em_start = (state == sp24_pkg::ST_EMIT) && (em_done < ncols_act) && !em_rd_v
                    && (!out_valid || out_fire) && (em_issue == em_done);
  assign em_load  = (state == sp24_pkg::ST_EMIT) && (em_done < ncols_act) && em_rd_v;

  always_comb begin
    ac_raddr = (state == sp24_pkg::ST_EMIT) ? em_issue[CW-1:0] : rd_col;
    ac_we    = wb_v;
    ac_waddr = wb_col;
    ac_wdata = wb_data;
    if (state == sp24_pkg::ST_CLEAR) begin
      ac_we = 1'b1; ac_waddr = clr[CW-1:0]; ac_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_col   <= col[CW-1:0];
    a_cur_d  <= a_cur;
    prod     <= $signed(a_cur_d) * $signed(ds_rdata);
    prod_col <= rd_col;
    wb_col   <= prod_col;
    wb_data  <= ac_rdata + AW'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0; prod_v <= 1'b0; wb_v <= 1'b0;
    end else begin
      rd_v   <= mac_issue;
      prod_v <= rd_v;
      wb_v   <= prod_v;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sp24_pkg::ST_IDLE: begin
        if (accept && in_data.mode) state_next = sp24_pkg::ST_MAC;
      end
      sp24_pkg::ST_MAC: begin
        if (pass_end && !(!second && item.second_valid))
          state_next = item.row_end ? sp24_pkg::ST_EMIT : sp24_pkg::ST_IDLE;
      end
      sp24_pkg::ST_EMIT: begin
        if (em_done >= ncols_act) state_next = sp24_pkg::ST_CLEAR;
      end
      sp24_pkg::ST_CLEAR: begin
        if (clr == (CW+1)'((1<<CW)-1)) state_next = sp24_pkg::ST_IDLE;
      end
      default: state_next = sp24_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sp24_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      n_cols <= 7'd64; k_cols <= 9'd256; m_rows <= 16'd65535;
      grp <= '0; row_cnt <= '0; out_valid <= 1'b0; em_rd_v <= 1'b0;
      second <= 1'b0; col <= '0; em_issue <= '0; em_done <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sp24_pkg::CfgNCols: n_cols <= cfg_wdata[6:0];
          sp24_pkg::CfgKCols: k_cols <= cfg_wdata[8:0];
          sp24_pkg::CfgMRows: m_rows <= cfg_wdata;
          default: ;
        endcase
      end
      out_valid <= em_load || (out_valid && !out_fire);
      em_rd_v   <= em_start;
      unique case (state)
        sp24_pkg::ST_IDLE: begin
          if (accept && in_data.mode) begin
            item <= in_data; second <= 1'b0; col <= '0;
          end
        end
        sp24_pkg::ST_MAC: begin
          if (mac_issue) col <= col + 7'd1;
          else if (pass_end) begin
            if (!second && item.second_valid) begin
              second <= 1'b1; col <= '0;
            end else begin
              grp <= (32'(grp) + 32'd1 >= 32'(GPR)) ? '0 : grp + GW'(1);
              if (item.row_end) begin
                em_issue <= '0; em_done <= '0;
              end
            end
          end
        end
        sp24_pkg::ST_EMIT: begin
          if (em_done >= ncols_act) begin
            grp <= '0; clr <= '0;
            row_cnt <= (m_rows != 16'd0 && row_cnt + 16'd1 >= m_rows) ? '0 : row_cnt + 16'd1;
          end else if (em_start) begin
            em_col <= em_issue[CW-1:0]; em_issue <= em_issue + 7'd1;
          end else if (em_load) begin
            out_data.c_row <= row_cnt;
            out_data.c_col <= 6'(em_col);
            out_data.c_value <= ac_rdata;
            out_data.last <= (em_done + 7'd1 == ncols_act);
            em_done <= em_done + 7'd1;
          end
        end
        sp24_pkg::ST_CLEAR: begin
          clr <= clr + (CW+1)'(1);
        end
        default: ;
      endcase
    end
  end
  assign em_last = out_data.last;

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != sp24_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
  a_last_cols: assert property (@(posedge clk) disable iff (rst)
    (out_valid && em_last) |-> (7'(out_data.c_col) + 7'd1 == ncols_act))
    else $error("last flag on wrong column");
  a_wb_mac: assert property (@(posedge clk) disable iff (rst)
    wb_v |-> (state == sp24_pkg::ST_MAC))
    else $error("write-back outside accumulation");
endmodule
`default_nettype wire

[bench/tb_sparse_2_4_matmul_row_engine_core.sv]
`default_nettype none
module tb_sparse_2_4_matmul_row_engine_core;

  localparam int Groups = (sp24_pkg::MaxInner + 3) / 4;
  localparam int Limit  = 4000000;

  // expected sums per column of the current row, checked oldest first
  class row_sum_board;
    sp24_pkg::out_item_t pending[$];
    logic signed [15:0] dense [0:sp24_pkg::MaxInner*sp24_pkg::MaxCols-1];
    logic [39:0] acc [0:sp24_pkg::MaxCols-1];
    int grp;
    int row;
    int ncols;
    int kcols;
    int mrows;
    int errors;
    int results;

    function new();
      for (int i = 0; i < sp24_pkg::MaxInner*sp24_pkg::MaxCols; i++) dense[i] = '0;
      for (int j = 0; j < sp24_pkg::MaxCols; j++) acc[j] = '0;
      grp = 0; row = 0; ncols = 64; kcols = 256; mrows = 65535;
      errors = 0; results = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      if (idx == sp24_pkg::CfgNCols) ncols = v[6:0];
      else if (idx == sp24_pkg::CfgKCols) kcols = v[8:0];
      else if (idx == sp24_pkg::CfgMRows) mrows = v;
    endfunction

    function void mac(logic signed [15:0] a, int k);
      int n;
      logic signed [39:0] p;
      n = ncols > sp24_pkg::MaxCols ? sp24_pkg::MaxCols : ncols;
      if (k >= kcols || k >= sp24_pkg::MaxInner) return;
      for (int j = 0; j < n; j++) begin
        p = 40'(a) * 40'(dense[k*sp24_pkg::MaxCols+j]);
        acc[j] = acc[j] + p;
      end
    endfunction

    function void note_input(sp24_pkg::in_item_t it);
      int n;
      sp24_pkg::out_item_t o;
      if (it.mode == 1'b0) begin
        dense[it.b_row*sp24_pkg::MaxCols + it.b_col] = it.b_value;
        return;
      end
      mac(it.a_value0, grp*4 + it.a_pos0);
      if (it.second_valid) mac(it.a_value1, grp*4 + it.a_pos1);
      grp = (grp + 1 >= Groups) ? 0 : grp + 1;
      if (!it.row_end) return;
      n = ncols > sp24_pkg::MaxCols ? sp24_pkg::MaxCols : ncols;
      for (int j = 0; j < n; j++) begin
        o.c_row = row[15:0];
        o.c_col = j[5:0];
        o.c_value = acc[j];
        o.last = (j + 1 == n);
        pending.push_back(o);
      end
      for (int j = 0; j < sp24_pkg::MaxCols; j++) acc[j] = '0;
      grp = 0;
      row = (row + 1) & 16'hffff;
      if (mrows != 0 && row >= mrows) row = 0;
    endfunction

    function void check_result(sp24_pkg::out_item_t got);
      sp24_pkg::out_item_t exp;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.c_row !== exp.c_row)
        $display("%0t: c_row exp %0d got %0d", $time, exp.c_row, got.c_row);
      if (got.c_col !== exp.c_col)
        $display("%0t: c_col exp %0d got %0d", $time, exp.c_col, got.c_col);
      if (got.c_value !== exp.c_value)
        $display("%0t: c_value exp %0d got %0d", $time, exp.c_value, got.c_value);
      if (got.last !== exp.last)
        $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sp24_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sp24_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  row_sum_board board = new();
  int cycles = 0;
  int in_idle_pct = 26;
  int out_idle_pct = 26;
  bit hold_off = 1'b0;
  int groups_sent = 0;

  sparse_2_4_matmul_row_engine_core dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: check on transfer, then pick next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // valid stays up after a transfer until the next idle cycle or the caller drops it
  task automatic send(sp24_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    board.set_reg(idx, v);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (board.pending.size() != 0) @(posedge clk);
    while (n < 200) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic load(int r, int c, logic signed [15:0] v);
    sp24_pkg::in_item_t it;
    it = '0;
    it.mode = 1'b0; it.b_row = r; it.b_col = c; it.b_value = v;
    it.a_value0 = $urandom; it.a_value1 = $urandom;
    it.a_pos0 = $urandom; it.a_pos1 = $urandom;
    it.second_valid = $urandom; it.row_end = $urandom;
    send(it);
  endtask

  // fill the rows that groups can reach with all columns
  task automatic load_rows(int kmax, bit extreme);
    logic signed [15:0] v;
    for (int r = 0; r < kmax; r++)
      for (int c = 0; c < sp24_pkg::MaxCols; c++) begin
        if (extreme) v = ($urandom_range(1)) ? 16'sh8000 : 16'sh7fff;
        else v = $urandom;
        load(r, c, v);
      end
  endtask

  // group at the current count; positions drawn at random
  task automatic group(logic signed [15:0] a0, logic signed [15:0] a1, bit sv, bit re);
    sp24_pkg::in_item_t it;
    it = $urandom;
    it.b_value = $urandom;
    it.mode = 1'b1;
    it.a_value0 = a0; it.a_value1 = a1;
    it.a_pos0 = $urandom; it.a_pos1 = $urandom;
    it.second_valid = sv; it.row_end = re;
    send(it);
    groups_sent++;
  endtask

  task automatic rand_rows(int nitems, int gmax);
    int g;
    g = 0;
    for (int i = 0; i < nitems; i++) begin
      g++;
      group($urandom, $urandom, $urandom, (g >= gmax) || ($urandom_range(5) == 0));
      if (board.grp == 0) g = 0;
    end
    group($urandom, $urandom, $urandom, 1'b1);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (sp24_pkg::MaxCols + 4) @(posedge clk);
    // small rows first: few columns, short inner size
    write_reg(sp24_pkg::CfgNCols, 16'd4);
    write_reg(sp24_pkg::CfgKCols, 16'd9);
    write_reg(sp24_pkg::CfgMRows, 16'd3);
    for (int c = 0; c < 4; c++) for (int r = 0; r < 12; r++)
      load(r, c, (r == 0) ? 16'sh8000 : (r == 1) ? 16'sh7fff : $urandom);
    load(255, 63, 16'sh1234);
    load(0, 0, 16'sh8000);
    group(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    group(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    group(16'sh0001, 16'shffff, 1'b1, 1'b1);
    group(16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
    group(16'sh0000, 16'sh0000, 1'b0, 1'b1);
    group(16'sh8000, 16'sh7fff, 1'b1, 1'b1);
    in_valid <= 1'b0;
    drain();
    write_reg(sp24_pkg::CfgNCols, 16'd0);
    group($urandom, $urandom, 1'b1, 1'b1);
    in_valid <= 1'b0;
    drain();
    write_reg(sp24_pkg::CfgNCols, 16'd1);
    write_reg(sp24_pkg::CfgKCols, 16'd1);
    write_reg(sp24_pkg::CfgMRows, 16'd0);
    rand_rows(15, 3);
    drain();
    // back pressure: receiver holds off while the sender keeps going
    write_reg(sp24_pkg::CfgNCols, 16'd4);
    write_reg(sp24_pkg::CfgKCols, 16'd12);
    write_reg(sp24_pkg::CfgMRows, 16'd65535);
    hold_off = 1'b1;
    fork
      rand_rows(20, 3);
      begin
        int n;
        n = 0;
        while (n < 600) begin
          @(posedge clk);
          n++;
        end
        hold_off = 1'b0;
      end
    join
    drain();
    // no idling stretch
    in_idle_pct = 0; out_idle_pct = 0;
    rand_rows(40, 3);
    drain();
    in_idle_pct = 26; out_idle_pct = 26;
    write_reg(sp24_pkg::CfgKCols, 16'd11);
    write_reg(sp24_pkg::CfgMRows, 16'd5);
    rand_rows(60, 3);
    drain();
    // full store width, extreme values, group count wrapping inside one row
    write_reg(sp24_pkg::CfgNCols, 16'd64);
    write_reg(sp24_pkg::CfgKCols, 16'd2);
    load_rows(2, 1'b1);
    in_idle_pct = 10;
    group(16'sh8000, 16'sh8000, 1'b1, 1'b1);
    for (int i = 0; i < Groups + 2; i++) group($urandom, $urandom, $urandom, 1'b0);
    group($urandom, $urandom, $urandom, 1'b1);
    in_valid <= 1'b0;
    drain();
    write_reg(sp24_pkg::CfgNCols, 16'd100);
    in_idle_pct = 26;
    rand_rows(15, 4);
    drain();
    $display("Covered %0d groups and %0d sums across several column, inner and row settings,",
             groups_sent, board.results);
    $display("including long receiver hold-off, group count wrap and extreme values.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
